/* sv/bist_pkg.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// bist_pkg
// Shared widths, defaults and request codes for the bounded id set table.
// ----------------------------------------------------------------------------
package bist_pkg;

    localparam int DEF_TABLE_DEPTH = 64;
    localparam int REQ_W           = 3;
    localparam int ID_W            = 32;
    localparam int IDX_W           = 6;

    typedef enum logic [REQ_W-1:0] {
        REQ_LOOKUP = 3'd0,
        REQ_ADD    = 3'd1,
        REQ_REMOVE = 3'd2,
        REQ_READ   = 3'd3,
        REQ_CLEAR  = 3'd4
    } t_req;

endpackage
`default_nettype wire

/* sv/bounded_id_set_table_unit.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// bounded_id_set_table_unit
// Packed set of distinct identifiers held in one synchronous RAM with a count.
// Clear, unused codes and reads past the count answer directly from idle; a
//   read passes through ST_RDW; lookup and add scan the entries, remove scans
//   them, then shifts down. The walk is set by the single-read-port RAM: one
//   entry per cycle.
// Throughput: one request at a time; start is taken from the o_valid cycle on.
// Reset clears the count and control only; the RAM keeps its old contents.
// The receiver cannot stall: each result shows for one cycle with o_valid.
// ----------------------------------------------------------------------------
module bounded_id_set_table_unit #(
    parameter int TABLE_DEPTH = bist_pkg::DEF_TABLE_DEPTH,
    parameter int CNT_W       = $clog2(TABLE_DEPTH + 1)
) (
    input  wire logic                       i_clk,
    input  wire logic                       i_rst_n,
    input  wire logic                       start,
    output logic                            busy,
    input  wire logic [bist_pkg::REQ_W-1:0] i_req_type,
    input  wire logic [bist_pkg::ID_W-1:0]  i_ident,
    input  wire logic [bist_pkg::IDX_W-1:0] i_entry_index,
    output logic                            o_valid,
    output logic                            o_success,
    output logic [CNT_W-1:0]                o_entry_count,
    output logic [bist_pkg::ID_W-1:0]       o_read_value
);
    import bist_pkg::*;

    localparam int ADDR_W = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
    localparam int CMP_W  = (CNT_W > IDX_W) ? CNT_W : IDX_W;
    localparam logic [CNT_W-1:0] DEPTH_C = CNT_W'(TABLE_DEPTH);
    localparam logic [CNT_W-1:0] ONE_C   = CNT_W'(1);

    typedef enum logic [3:0] {
        ST_IDLE  = 4'b0001,
        ST_SCAN  = 4'b0010,
        ST_SHIFT = 4'b0100,
        ST_RDW   = 4'b1000
    } t_state;

    logic [ID_W-1:0] id_mem [TABLE_DEPTH];

    t_state           r_state,   n_state;
    t_req             r_req,     n_req;
    logic [ID_W-1:0]  r_id,      n_id;
    logic [CNT_W-1:0] r_count,   n_count;
    logic [CNT_W-1:0] r_ptr,     n_ptr;
    logic [CNT_W-1:0] r_cmp_ptr, n_cmp_ptr;
    logic             r_cmp_vld, n_cmp_vld;
    logic             r_out_vld, n_out_vld;
    logic             r_success, n_success;
    logic [ID_W-1:0]  r_value,   n_value;
    logic [ID_W-1:0]  r_rd_data;

    logic [ADDR_W-1:0] rd_addr;
    logic              wr_en;
    logic [ADDR_W-1:0] wr_addr;
    logic [ID_W-1:0]   wr_data;
    logic [CMP_W-1:0]  idx_ext;
    logic [CMP_W-1:0]  cnt_ext;
    logic              hit;
    logic [CNT_W-1:0]  shift_dst;

    assign idx_ext   = CMP_W'(i_entry_index);
    assign cnt_ext   = CMP_W'(r_count);
    assign hit       = r_cmp_vld && (r_rd_data == r_id);
    assign shift_dst = r_cmp_ptr - ONE_C;
    assign rd_addr   = (r_state == ST_IDLE) ? idx_ext[ADDR_W-1:0] : r_ptr[ADDR_W-1:0];

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            id_mem[wr_addr] <= wr_data;
        end
        r_rd_data <= id_mem[rd_addr];
    end

    always_comb begin
        n_state   = r_state;
        n_req     = r_req;
        n_id      = r_id;
        n_count   = r_count;
        n_ptr     = r_ptr;
        n_cmp_ptr = r_cmp_ptr;
        n_cmp_vld = 1'b0;
        n_out_vld = 1'b0;
        n_success = r_success;
        n_value   = r_value;
        wr_en     = 1'b0;
        wr_addr   = shift_dst[ADDR_W-1:0];
        wr_data   = r_rd_data;

        case (r_state)
            ST_IDLE: begin
                if (start) begin
                    n_req     = t_req'(i_req_type);
                    n_id      = i_ident;
                    n_ptr     = '0;
                    n_success = 1'b0;
                    n_value   = '0;
                    case (t_req'(i_req_type))
                        REQ_LOOKUP, REQ_ADD, REQ_REMOVE: begin
                            n_state = ST_SCAN;
                        end
                        REQ_READ: begin
                            if (idx_ext < cnt_ext) begin
                                n_state = ST_RDW;
                            end else begin
                                n_out_vld = 1'b1;
                            end
                        end
                        REQ_CLEAR: begin
                            n_count   = '0;
                            n_success = 1'b1;
                            n_out_vld = 1'b1;
                        end
                        default: begin
                            n_out_vld = 1'b1;
                        end
                    endcase
                end
            end
            ST_SCAN: begin
                if (hit) begin
                    if (r_req == REQ_REMOVE) begin
                        n_state = ST_SHIFT;
                        n_ptr   = r_cmp_ptr + ONE_C;
                    end else begin
                        n_state   = ST_IDLE;
                        n_success = 1'b1;
                        n_out_vld = 1'b1;
                    end
                end else if (r_ptr >= r_count) begin
                    n_state   = ST_IDLE;
                    n_out_vld = 1'b1;
                    if ((r_req == REQ_ADD) && (r_count < DEPTH_C)) begin
                        wr_en     = 1'b1;
                        wr_addr   = r_count[ADDR_W-1:0];
                        wr_data   = r_id;
                        n_count   = r_count + ONE_C;
                        n_success = 1'b1;
                    end
                end else begin
                    n_ptr     = r_ptr + ONE_C;
                    n_cmp_ptr = r_ptr;
                    n_cmp_vld = 1'b1;
                end
            end
            ST_SHIFT: begin
                wr_en = r_cmp_vld;
                if (r_ptr < r_count) begin
                    n_ptr     = r_ptr + ONE_C;
                    n_cmp_ptr = r_ptr;
                    n_cmp_vld = 1'b1;
                end else if (!r_cmp_vld) begin
                    n_state   = ST_IDLE;
                    n_count   = r_count - ONE_C;
                    n_success = 1'b1;
                    n_out_vld = 1'b1;
                end
            end
            ST_RDW: begin
                n_state   = ST_IDLE;
                n_success = 1'b1;
                n_value   = r_rd_data;
                n_out_vld = 1'b1;
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= ST_IDLE;
            r_count   <= '0;
            r_cmp_vld <= 1'b0;
            r_out_vld <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_count   <= n_count;
            r_cmp_vld <= n_cmp_vld;
            r_out_vld <= n_out_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        r_req     <= n_req;
        r_id      <= n_id;
        r_ptr     <= n_ptr;
        r_cmp_ptr <= n_cmp_ptr;
        r_success <= n_success;
        r_value   <= n_value;
    end

    assign busy          = (r_state != ST_IDLE);
    assign o_valid       = r_out_vld;
    assign o_success     = r_success;
    assign o_entry_count = r_count;
    assign o_read_value  = r_value;

endmodule
`default_nettype wire

/* sv/bist_chk.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// bist_chk
// Port-level checks for the bounded id set table, bound to the table unit.
// ----------------------------------------------------------------------------
module bist_chk #(
    parameter int TABLE_DEPTH = bist_pkg::DEF_TABLE_DEPTH,
    parameter int CNT_W       = $clog2(TABLE_DEPTH + 1)
) (
    input wire logic                       i_clk,
    input wire logic                       i_rst_n,
    input wire logic                       start,
    input wire logic                       busy,
    input wire logic                       o_valid,
    input wire logic                       o_success,
    input wire logic [CNT_W-1:0]           o_entry_count,
    input wire logic [bist_pkg::ID_W-1:0]  o_read_value
);
    import bist_pkg::*;

    localparam logic [CNT_W-1:0] DEPTH_C = CNT_W'(TABLE_DEPTH);

    a_result_follows_work: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> $past(busy) || $past(start))
        else $error("result without a transfer in progress");

    a_busy_after_start: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy && !o_valid) |=> (busy || o_valid))
        else $error("accepted request neither busy nor answered");

    a_count_bounded: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_entry_count <= DEPTH_C)
        else $error("count beyond table depth");

    a_fail_reads_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !o_success) |-> (o_read_value == '0))
        else $error("failed request returned a value");

    a_count_moves_with_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!o_valid && $past(i_rst_n)) |-> $stable(o_entry_count))
        else $error("count changed without a result transfer");

endmodule

bind bounded_id_set_table_unit bist_chk #(
    .TABLE_DEPTH (TABLE_DEPTH),
    .CNT_W       (CNT_W)
) u_bist_chk (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .start         (start),
    .busy          (busy),
    .o_valid       (o_valid),
    .o_success     (o_success),
    .o_entry_count (o_entry_count),
    .o_read_value  (o_read_value)
);
`default_nettype wire
